[rtl/core/leg_forward_kinematics_macros.svh]
// assertion helpers
`ifndef LEG_FORWARD_KINEMATICS_MACROS_SVH
`define LEG_FORWARD_KINEMATICS_MACROS_SVH

`define LFK_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfk check failed");

`define LFK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfk check failed");

`define LFK_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lfk reset check failed");

`endif

[rtl/core/lfk_pkg.sv]
package lfk_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_GAIN  = 652032875;
  localparam int OUT_W        = 27;
  localparam int ANGLE_W      = 16;
  localparam int LEN_W        = 16;
  localparam int CFG_IDX_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_HIP   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THIGH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOOT  = 8'd3;

  // arctan(2^-i) in 2^32 per turn
  localparam logic [31:0] ATAN_TURN32 [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

endpackage

[rtl/core/lfk_cordic.sv]
module lfk_cordic #(
  parameter int ANGLE_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [lfk_pkg::ANGLE_W-1:0]       angle,
  output logic signed [FRACTION_BITS+1:0]   cos_o,
  output logic signed [FRACTION_BITS+1:0]   sin_o
);

  localparam int XW    = 34;
  localparam int ZW    = 33;
  localparam int CW    = FRACTION_BITS + 2;
  localparam int STEPS = lfk_pkg::CORDIC_STEPS;
  localparam int SH    = lfk_pkg::CORDIC_FRAC - FRACTION_BITS;
  localparam logic [31:0] KEEP = 32'hFFFF_FFFF << (32 - ANGLE_BITS);
  localparam logic signed [XW-1:0] HALF = XW'(64'sd1 <<< (SH - 1));
  localparam logic signed [XW-1:0] LIM  = XW'(64'sd1 <<< FRACTION_BITS);

  logic [31:0]             phase;
  logic signed [XW-1:0]    x_r [STEPS];
  logic signed [XW-1:0]    y_r [STEPS];
  logic signed [ZW-1:0]    z_r [STEPS];
  logic [1:0]              q_r [STEPS];
  logic signed [XW-1:0]    cr, sr, cc, sc;
  logic signed [CW-1:0]    cn, sn;
  logic signed [CW-1:0]    cos_r, sin_r;

  assign phase = {angle, 16'h0000} & KEEP;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [XW-1:0] xp, yp, dx, dy;
    logic signed [ZW-1:0] zp, at;
    logic [1:0]           qp;
    if (i == 0) begin : g_first
      assign xp = XW'(lfk_pkg::CORDIC_GAIN);
      assign yp = '0;
      assign zp = ZW'({3'b000, phase[29:0]});
      assign qp = phase[31:30];
    end else begin : g_next
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
      assign qp = q_r[i-1];
    end
    assign dx = yp >>> i;
    assign dy = xp >>> i;
    assign at = ZW'({1'b0, lfk_pkg::ATAN_TURN32[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zp[ZW-1]) begin
          x_r[i] <= xp - dx;
          y_r[i] <= yp + dy;
          z_r[i] <= zp - at;
        end else begin
          x_r[i] <= xp + dx;
          y_r[i] <= yp - dy;
          z_r[i] <= zp + at;
        end
        q_r[i] <= qp;
      end
    end
  end

  always_comb begin
    cr = (x_r[STEPS-1] + HALF) >>> SH;
    sr = (y_r[STEPS-1] + HALF) >>> SH;
    cc = cr;
    sc = sr;
    if (cr > LIM)  cc = LIM;
    if (cr < -LIM) cc = -LIM;
    if (sr > LIM)  sc = LIM;
    if (sr < -LIM) sc = -LIM;
    unique case (q_r[STEPS-1])
      2'd0: begin cn = CW'(cc);  sn = CW'(sc);  end
      2'd1: begin cn = -CW'(sc); sn = CW'(cc);  end
      2'd2: begin cn = -CW'(cc); sn = -CW'(sc); end
      default: begin cn = CW'(sc); sn = -CW'(cc); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cn;
      sin_r <= sn;
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

[rtl/core/lfk_rotate.sv]
module lfk_rotate #(
  parameter int FRACTION_BITS = 16,
  parameter int VW            = 29,
  parameter int AXIS          = 0
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [FRACTION_BITS+1:0] cos_i,
  input  logic signed [FRACTION_BITS+1:0] sin_i,
  input  logic signed [VW-1:0]            x_i,
  input  logic signed [VW-1:0]            y_i,
  input  logic signed [VW-1:0]            z_i,
  input  logic signed [VW-1:0]            bias_z,
  output logic signed [VW-1:0]            x_o,
  output logic signed [VW-1:0]            y_o,
  output logic signed [VW-1:0]            z_o
);

  localparam int CW = FRACTION_BITS + 2;
  localparam int PW = CW + VW + 1;
  localparam logic signed [PW-1:0] HALF = PW'(64'sd1 <<< (FRACTION_BITS - 1));

  logic signed [VW-1:0] a, b, o;
  logic signed [PW-1:0] p_ac_r, p_sb_r, p_sa_r, p_cb_r;
  logic signed [VW-1:0] o_r;
  logic signed [PW-1:0] sum_a, sum_b;
  logic signed [VW-1:0] na, nb;
  logic signed [VW-1:0] x_r, y_r, z_r;
  logic signed [VW-1:0] xn, yn, zn;

  // (a, b) is the rotated pair, o the axis coordinate
  always_comb begin
    unique case (AXIS)
      0: begin a = y_i; b = z_i; o = x_i; end
      1: begin a = z_i; b = x_i; o = y_i; end
      default: begin a = x_i; b = y_i; o = z_i; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ac_r <= PW'(cos_i * a);
      p_sb_r <= PW'(sin_i * b);
      p_sa_r <= PW'(sin_i * a);
      p_cb_r <= PW'(cos_i * b);
      o_r    <= o;
    end
  end

  always_comb begin
    sum_a = p_ac_r - p_sb_r + HALF;
    sum_b = p_sa_r + p_cb_r + HALF;
    na    = VW'(sum_a >>> FRACTION_BITS);
    nb    = VW'(sum_b >>> FRACTION_BITS);
    unique case (AXIS)
      0: begin xn = o_r; yn = na;  zn = nb;  end
      1: begin xn = nb;  yn = o_r; zn = na;  end
      default: begin xn = na; yn = nb; zn = o_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= xn;
      y_r <= yn;
      z_r <= zn + bias_z;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

[rtl/core/leg_forward_kinematics.sv]
// Leg forward kinematics: six joint angles in, tip position out.
// Input channel in_*: one word per pose, six 16-bit binary angles
// (65536 per turn). Output channel out_*: one word per pose, tip x, y, z
// as signed 27-bit fixed point with FRACTION_BITS fraction bits.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write the four link lengths
// (Q8.8); index 0 hip, 1 thigh, 2 shin, 3 foot; other indexes are ignored.
// Write lengths only while no pose is in flight.
// The pipeline has 30 CORDIC micro-rotation stages plus one rounding stage
// for all six sin/cos pairs in parallel, two stages per joint rotation
// (multiply, then round and add link), and one saturation stage.
// Throughput is one pose per cycle while the output is not stalled; the whole pipeline advances together.
// When out_tready is low while out_tvalid is high the pipeline holds and
// in_tready drops, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and sets every link
// length to 1.0.
module leg_forward_kinematics #(
  parameter int ANGLE_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // hip_yaw, hip_roll, hip_pitch, knee_pitch, ankle_pitch, ankle_roll
  input  logic [95:0]                     in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tip_x, tip_y, tip_z, zero pad
  output logic [87:0]                     out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [lfk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lfk_pkg::LEN_W-1:0]       cfg_wdata
);

`include "leg_forward_kinematics_macros.svh"

  localparam int CW  = FRACTION_BITS + 2;
  localparam int VW  = FRACTION_BITS + 13;
  localparam int OW  = lfk_pkg::OUT_W;
  localparam int AW  = lfk_pkg::ANGLE_W;
  localparam int LAT = lfk_pkg::CORDIC_STEPS + 1 + 12 + 1;

  logic                 en;
  logic [LAT-1:0]       vld_r;
  logic [lfk_pkg::LEN_W-1:0] len_hip_r, len_thigh_r, len_shin_r, len_foot_r;
  logic signed [CW-1:0] c_all [6];
  logic signed [CW-1:0] s_all [6];
  logic signed [CW-1:0] rc [6];
  logic signed [CW-1:0] rs [6];
  logic signed [VW-1:0] vx [7];
  logic signed [VW-1:0] vy [7];
  logic signed [VW-1:0] vz [7];
  logic signed [VW-1:0] bias [6];
  logic [OW-1:0]        tx_r, ty_r, tz_r;

  function automatic logic signed [VW-1:0] len_fix(input logic [lfk_pkg::LEN_W-1:0] l);
    return VW'({1'b0, l}) <<< (FRACTION_BITS - 8);
  endfunction

  function automatic logic [OW-1:0] sat(input logic signed [VW-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    if (w > 64'sd67108863)  return {1'b0, {(OW-1){1'b1}}};
    if (w < -64'sd67108864) return {1'b1, {(OW-1){1'b0}}};
    return OW'(w);
  endfunction

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      len_hip_r   <= 16'd256;
      len_thigh_r <= 16'd256;
      len_shin_r  <= 16'd256;
      len_foot_r  <= 16'd256;
    end else begin
      if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
      if (cfg_wr_en) begin
        unique case (cfg_index)
          lfk_pkg::REG_HIP:   len_hip_r   <= cfg_wdata;
          lfk_pkg::REG_THIGH: len_thigh_r <= cfg_wdata;
          lfk_pkg::REG_SHIN:  len_shin_r  <= cfg_wdata;
          lfk_pkg::REG_FOOT:  len_foot_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  for (genvar j = 0; j < 6; j++) begin : g_cordic
    lfk_cordic #(
      .ANGLE_BITS(ANGLE_BITS),
      .FRACTION_BITS(FRACTION_BITS)
    ) u_cordic (
      .clk(clk),
      .en(en),
      .angle(in_tdata[j*AW +: AW]),
      .cos_o(c_all[j]),
      .sin_o(s_all[j])
    );
  end

  // rotation k uses joint 5-k, delayed by 2k stages
  for (genvar k = 0; k < 6; k++) begin : g_cs
    if (k == 0) begin : g_direct
      assign rc[k] = c_all[5];
      assign rs[k] = s_all[5];
    end else begin : g_dly
      logic signed [CW-1:0] dc_r [2*k];
      logic signed [CW-1:0] ds_r [2*k];
      always_ff @(posedge clk) begin
        if (en) begin
          dc_r[0] <= c_all[5-k];
          ds_r[0] <= s_all[5-k];
          for (int d = 1; d < 2*k; d++) begin
            dc_r[d] <= dc_r[d-1];
            ds_r[d] <= ds_r[d-1];
          end
        end
      end
      assign rc[k] = dc_r[2*k-1];
      assign rs[k] = ds_r[2*k-1];
    end
  end

  assign vx[0]   = '0;
  assign vy[0]   = '0;
  assign vz[0]   = len_fix(len_foot_r);
  assign bias[0] = '0;
  assign bias[1] = len_fix(len_shin_r);
  assign bias[2] = len_fix(len_thigh_r);
  assign bias[3] = '0;
  assign bias[4] = '0;
  assign bias[5] = len_fix(len_hip_r);

  // ankle roll, ankle pitch, knee, hip pitch, hip roll, hip yaw
  for (genvar k = 0; k < 6; k++) begin : g_rot
    localparam int AX = (k == 0 || k == 4) ? 0 : ((k == 5) ? 2 : 1);
    lfk_rotate #(
      .FRACTION_BITS(FRACTION_BITS),
      .VW(VW),
      .AXIS(AX)
    ) u_rot (
      .clk(clk),
      .en(en),
      .cos_i(rc[k]),
      .sin_i(rs[k]),
      .x_i(vx[k]),
      .y_i(vy[k]),
      .z_i(vz[k]),
      .bias_z(bias[k]),
      .x_o(vx[k+1]),
      .y_o(vy[k+1]),
      .z_o(vz[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r <= sat(vx[6]);
      ty_r <= sat(vy[6]);
      tz_r <= sat(vz[6]);
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {7'b0, tz_r, ty_r, tx_r};

  `LFK_ASSERT_NEXT(a_accept_enters, in_tvalid && in_tready, vld_r[0])
  `LFK_ASSERT_NEXT(a_hold_on_stall, out_tvalid && !out_tready, $stable(vld_r) && $stable(out_tdata))
  `LFK_ASSERT_SAME(a_ready_follows, out_tvalid && !out_tready, !in_tready)
  `LFK_ASSERT_RESET(a_reset_empty, !rst_n, vld_r == '0)

endmodule
